// File: design/draw_command_stream_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Draw command stream parser: assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef DRAW_COMMAND_STREAM_PARSER_UNIT_DEFINES_SVH
`define DRAW_COMMAND_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define DCSP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DCSP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/dcsp_pkg.sv
// ----------------------------------------------------------------------------
// Draw command stream parser package
// Phase and result kind codes, parser state and result records, word table.
// ----------------------------------------------------------------------------
package dcsp_pkg;

   localparam int NUM_CODES = 19;
   localparam logic [4:0] CODE_TEXT = 5'd8;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WORDS = 2'd1,
      PH_TLEN  = 2'd2,
      PH_TCHR  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_END   = 2'd2,
      KIND_TRUNC = 2'd3
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [4:0]  code;
      logic [2:0]  words_seen;
      logic [1:0]  byte_in_word;
      logic [23:0] partial;
      logic [7:0]  text_left;
   } parse_state_type;

   typedef struct packed {
      logic        valid;
      logic [4:0]  code;
      kind_type    kind;
      logic [2:0]  pos;
      logic [31:0] payload;
      logic        done;
   } result_type;

   // argument words per command code
   function automatic logic [3:0] word_count(input logic [4:0] code);
      logic [3:0] cnt;
      case (code)
         5'd0, 5'd1, 5'd10, 5'd15, 5'd16: cnt = 4'd4;
         5'd2, 5'd3:                      cnt = 4'd1;
         5'd5, 5'd8, 5'd9:                cnt = 4'd2;
         5'd11, 5'd12:                    cnt = 4'd6;
         5'd13, 5'd14:                    cnt = 4'd8;
         5'd17, 5'd18:                    cnt = 4'd3;
         default:                         cnt = 4'd0;
      endcase
      return cnt;
   endfunction

   // back to idle: counters cleared, code kept
   function automatic parse_state_type go_idle(input parse_state_type cur);
      parse_state_type s;
      s              = cur;
      s.phase        = PH_IDLE;
      s.words_seen   = 3'd0;
      s.byte_in_word = 2'd0;
      s.partial      = 24'd0;
      s.text_left    = 8'd0;
      return s;
   endfunction

endpackage

// File: design/dcsp_parse_core.sv
// ----------------------------------------------------------------------------
// Draw command stream parser: step logic
// Next parser state and the optional result for one buffer byte.
// ----------------------------------------------------------------------------
module dcsp_parse_core
   import dcsp_pkg::*;
(
   input  parse_state_type state_cur,
   input  logic [7:0]      data_byte,
   input  logic            buffer_end,
   output parse_state_type state_nxt,
   output result_type      result
);

   logic       code_ok;
   logic [3:0] new_cnt;
   logic [3:0] cur_cnt;
   logic       word_ends;
   logic       word_last;
   logic       finishes;

   assign code_ok   = data_byte < 8'(NUM_CODES);
   assign new_cnt   = word_count(data_byte[4:0]);
   assign cur_cnt   = word_count(state_cur.code);
   assign word_ends = state_cur.byte_in_word == 2'd3;
   assign word_last = ({1'b0, state_cur.words_seen} + 4'd1) >= cur_cnt;
   assign finishes  = word_last && (state_cur.code != CODE_TEXT);

   // next state
   always_comb begin
      state_nxt = state_cur;
      case (state_cur.phase)
         PH_IDLE: begin
            if (code_ok) begin
               state_nxt      = go_idle(state_cur);
               state_nxt.code = data_byte[4:0];
               if (new_cnt != 4'd0 && !buffer_end) begin
                  state_nxt.phase = PH_WORDS;
               end
            end
         end
         PH_WORDS: begin
            if (!word_ends) begin
               if (buffer_end) begin
                  state_nxt = go_idle(state_cur);
               end else begin
                  state_nxt.partial[{state_cur.byte_in_word, 3'b000} +: 8] = data_byte;
                  state_nxt.byte_in_word = state_cur.byte_in_word + 2'd1;
               end
            end else if (buffer_end && !finishes) begin
               state_nxt = go_idle(state_cur);
            end else if (word_last) begin
               state_nxt = go_idle(state_cur);
               if (state_cur.code == CODE_TEXT) begin
                  state_nxt.phase = PH_TLEN;
               end
            end else begin
               state_nxt.byte_in_word = 2'd0;
               state_nxt.partial      = 24'd0;
               state_nxt.words_seen   = state_cur.words_seen + 3'd1;
            end
         end
         PH_TLEN: begin
            if (data_byte == 8'd0 || buffer_end) begin
               state_nxt = go_idle(state_cur);
            end else begin
               state_nxt.text_left = data_byte;
               state_nxt.phase     = PH_TCHR;
            end
         end
         PH_TCHR: begin
            if (state_cur.text_left <= 8'd1 || buffer_end) begin
               state_nxt = go_idle(state_cur);
            end else begin
               state_nxt.text_left = state_cur.text_left - 8'd1;
            end
         end
         default: state_nxt = go_idle(state_cur);
      endcase
   end

   // result
   always_comb begin
      result         = '0;
      result.code    = state_cur.code;
      result.kind    = KIND_TRUNC;
      result.pos     = state_cur.words_seen;
      result.payload = 32'd0;
      result.done    = 1'b1;
      case (state_cur.phase)
         PH_IDLE: begin
            result.code  = data_byte[4:0];
            result.pos   = 3'd0;
            result.valid = code_ok && (new_cnt == 4'd0 || buffer_end);
            result.kind  = (new_cnt == 4'd0) ? KIND_END : KIND_TRUNC;
         end
         PH_WORDS: begin
            if (!word_ends) begin
               result.valid = buffer_end;
            end else if (buffer_end && !finishes) begin
               result.valid = 1'b1;
            end else begin
               result.valid   = 1'b1;
               result.kind    = KIND_WORD;
               result.payload = {data_byte, state_cur.partial};
               result.done    = finishes;
            end
         end
         PH_TLEN: begin
            result.valid = (data_byte == 8'd0) || buffer_end;
            if (data_byte == 8'd0) begin
               result.kind = KIND_END;
               result.pos  = 3'd0;
            end
         end
         PH_TCHR: begin
            result.valid = 1'b1;
            if (state_cur.text_left <= 8'd1 || !buffer_end) begin
               result.kind    = KIND_CHAR;
               result.pos     = 3'd0;
               result.payload = {24'd0, data_byte};
               result.done    = state_cur.text_left <= 8'd1;
            end
         end
         default: result.valid = 1'b0;
      endcase
   end

endmodule

// File: design/draw_command_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// Draw command stream parser unit
// Parses a drawing command buffer one byte per word, gives argument words,
// text characters, end markers and truncation errors.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one buffer byte per word, req_buffer_end flags the last
//    byte of a buffer. Taken when req_valid is high and req_stall low.
//  - rsp_ channel: at most one result per byte; taken when rsp_valid is high
//    and rsp_stall low. rsp_command_done marks a command's final result.
//  - Path: a result shows on rsp_ once its byte has passed the input
//    register, then the result register.
//  - Throughput: one byte per cycle while no held result is stalled; the
//    parser step is a single pass of logic between the input register and the result register.
//  - Stall: a held result keeps the input register full; req_stall rises
//    only while both registers are full and the receiver stalls.
//  - Reset (synchronous): parser idle, counters and code zero, both
//    registers empty.
// ----------------------------------------------------------------------------
`include "draw_command_stream_parser_unit_defines.svh"

module draw_command_stream_parser_unit
   import dcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_command_code,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_arg_position,
   output logic [31:0] rsp_payload_word,
   output logic        rsp_command_done
);

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_end_ff, in_end_in;

   // parser state
   parse_state_type state_ff, state_in;
   parse_state_type state_nxt;

   // result register
   logic            out_valid_ff, out_valid_in;
   result_type      out_ff, out_in;
   result_type      step_res;

   logic            advance;   // result register can take a new value
   logic            process;   // byte in input register is parsed this cycle

   assign advance   = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   dcsp_parse_core u_core (
      .state_cur  (state_ff),
      .data_byte  (in_byte_ff),
      .buffer_end (in_end_ff),
      .state_nxt  (state_nxt),
      .result     (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_data_byte;
         in_end_in   = req_buffer_end;
      end
   end

   always_comb begin
      state_in     = process ? state_nxt : state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = process && step_res.valid;
         if (process && step_res.valid) begin
            out_in = step_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= go_idle('0);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command_code = out_ff.code;
   assign rsp_result_kind  = 2'(out_ff.kind);
   assign rsp_arg_position = out_ff.pos;
   assign rsp_payload_word = out_ff.payload;
   assign rsp_command_done = out_ff.done;

   // a command's final result leaves the parser idle
   `DCSP_ASSERT_NXT(a_done_goes_idle, process && step_res.valid && step_res.done,
      state_ff.phase == PH_IDLE, "parser not idle after final result")

   // partial word only lives inside the argument phase
   `DCSP_ASSERT_IMP(a_partial_clear, state_ff.phase != PH_WORDS,
      state_ff.byte_in_word == 2'd0 && state_ff.partial == 24'd0,
      "stale partial word outside argument phase")

   // argument words stay within the command's word count
   `DCSP_ASSERT_IMP(a_word_pos, rsp_valid && out_ff.kind == KIND_WORD,
      {1'b0, rsp_arg_position} < word_count(rsp_command_code),
      "argument position beyond word count")

   // truncation is always the final result of its command
   `DCSP_ASSERT_IMP(a_trunc_done, rsp_valid && out_ff.kind == KIND_TRUNC,
      rsp_command_done && rsp_payload_word == 32'd0,
      "truncation result malformed")

endmodule
